// ===== hw/rtl/mkd_pkg.sv =====
// Morse keying decoder package: payload structs, constants, lookup tables.
// No dependencies.
package mkd_pkg;

    localparam int MaxElements = 8;
    localparam int TimeWidth   = 32;

    localparam logic [7:0] ChStar  = 8'd42;
    localparam logic [7:0] ChSpace = 8'd32;
    localparam logic [7:0] ChLbr   = 8'd91;
    localparam logic [7:0] ChRbr   = 8'd93;

    localparam logic [7:0] CodeAr    = 8'h2A;
    localparam logic [7:0] CodeVa    = 8'h45;
    localparam logic [7:0] CodeBt    = 8'h31;
    localparam logic [7:0] CodeToJp  = 8'h67;
    localparam logic [7:0] CodeToEn  = 8'h22;
    localparam logic [7:0] CodeOpen  = 8'h6D;
    localparam logic [7:0] CodeClose = 8'h52;

    typedef struct packed {
        logic        key_level;
        logic [31:0] sample_time_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_run;
    } out_item_t;

    // one decoded request from front to back
    typedef struct packed {
        logic       do_char;
        logic [7:0] code;
        logic       do_space;
    } cmd_t;

    function automatic logic [7:0] en_lookup(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h05: r = 8'd65;  8'h18: r = 8'd66;  8'h1A: r = 8'd67;  8'h0C: r = 8'd68;
            8'h02: r = 8'd69;  8'h12: r = 8'd70;  8'h0E: r = 8'd71;  8'h10: r = 8'd72;
            8'h04: r = 8'd73;  8'h17: r = 8'd74;  8'h0D: r = 8'd75;  8'h14: r = 8'd76;
            8'h07: r = 8'd77;  8'h06: r = 8'd78;  8'h0F: r = 8'd79;  8'h16: r = 8'd80;
            8'h1D: r = 8'd81;  8'h0A: r = 8'd82;  8'h08: r = 8'd83;  8'h03: r = 8'd84;
            8'h09: r = 8'd85;  8'h11: r = 8'd86;  8'h0B: r = 8'd87;  8'h19: r = 8'd88;
            8'h1B: r = 8'd89;  8'h1C: r = 8'd90;
            8'h2F: r = 8'd49;  8'h27: r = 8'd50;  8'h23: r = 8'd51;  8'h21: r = 8'd52;
            8'h20: r = 8'd53;  8'h30: r = 8'd54;  8'h38: r = 8'd55;  8'h3C: r = 8'd56;
            8'h3E: r = 8'd57;  8'h3F: r = 8'd48;  8'h32: r = 8'd47;  8'h4C: r = 8'd63;
            8'h73: r = 8'd44;  8'h55: r = 8'd46;  8'h5A: r = 8'd64;  8'h36: r = 8'd40;
            8'h6D: r = 8'd41;
            default: r = ChStar;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] jp_lookup(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h17: r = 8'd166; 8'h2D: r = 8'd176; 8'h3B: r = 8'd177; 8'h05: r = 8'd178;
            8'h09: r = 8'd179; 8'h37: r = 8'd180; 8'h28: r = 8'd181; 8'h14: r = 8'd182;
            8'h34: r = 8'd183; 8'h11: r = 8'd184; 8'h1B: r = 8'd185; 8'h1F: r = 8'd186;
            8'h35: r = 8'd187; 8'h3A: r = 8'd188; 8'h3D: r = 8'd189; 8'h2E: r = 8'd190;
            8'h1E: r = 8'd191; 8'h06: r = 8'd192; 8'h12: r = 8'd193; 8'h16: r = 8'd194;
            8'h2B: r = 8'd195; 8'h24: r = 8'd196; 8'h0A: r = 8'd197; 8'h1A: r = 8'd198;
            8'h10: r = 8'd199; 8'h1D: r = 8'd200; 8'h13: r = 8'd201; 8'h18: r = 8'd202;
            8'h39: r = 8'd203; 8'h1C: r = 8'd204; 8'h02: r = 8'd205; 8'h0C: r = 8'd206;
            8'h19: r = 8'd207; 8'h25: r = 8'd208; 8'h03: r = 8'd209; 8'h31: r = 8'd210;
            8'h32: r = 8'd211; 8'h0B: r = 8'd212; 8'h33: r = 8'd213; 8'h07: r = 8'd214;
            8'h08: r = 8'd215; 8'h0E: r = 8'd216; 8'h36: r = 8'd217; 8'h0F: r = 8'd218;
            8'h15: r = 8'd219; 8'h0D: r = 8'd220; 8'h2A: r = 8'd221; 8'h04: r = 8'd222;
            8'h26: r = 8'd223;
            8'h2F: r = 8'd49;  8'h27: r = 8'd50;  8'h23: r = 8'd51;  8'h21: r = 8'd52;
            8'h20: r = 8'd53;  8'h30: r = 8'd54;  8'h38: r = 8'd55;  8'h3C: r = 8'd56;
            8'h3E: r = 8'd57;  8'h3F: r = 8'd48;  8'h4C: r = 8'd63;  8'h55: r = 8'd46;
            8'h73: r = 8'd44;  8'h54: r = 8'd163;
            default: r = ChStar;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/morse_keying_decoder.sv =====
// Morse keying decoder top level: front end, command queue, back end.
// Depends on mkd_pkg, mkd_front, mkd_queue, mkd_back.
//
//   channel | handshake             | payload
//   in      | in_valid / in_ready   | in_data  (mkd_pkg::in_item_t)
//   out     | out_valid / out_ready | out_data (mkd_pkg::out_item_t)
//   cfg     | cfg_we                | cfg_wdata (dot threshold, ms)
//
// One sample per cycle; the front end resolves it in the accept cycle.
// A sample that ends a character or word queues one request; the back end
// emits its 1..5 codes one per cycle while out_ready is high, from the head
// of a 2-deep queue; in_ready drops only while it is full. Reset: async, active low.
module morse_keying_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  mkd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mkd_pkg::out_item_t out_data
);

    logic          f_valid, f_ready, q_valid, q_ready;
    mkd_pkg::cmd_t f_cmd, q_cmd;

    mkd_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_data,
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    mkd_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    mkd_back u_back (
        .clk, .rst_n,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid, .out_ready, .out_data
    );

endmodule

// ===== hw/rtl/mkd_front.sv =====
// Front end: key edge timing, element shifting, character/space detection.
// Depends on mkd_pkg.
module mkd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [14:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  mkd_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output mkd_pkg::cmd_t     cmd
);

    localparam int TW = mkd_pkg::TimeWidth;

    logic [14:0]   thr_reg;
    logic          prev_reg;
    logic [TW-1:0] down_start_reg;
    logic [TW-1:0] up_start_reg;
    logic [14:0]   dot_reg;
    logic [7:0]    code_reg;
    logic [3:0]    count_reg;
    logic          space_reg;
    logic [16:0]   dot3;
    logic [17:0]   dot7;

    logic [TW-1:0] now, down_len, up_len;
    logic          acc, is_dot;
    logic [3:0]    cnt_inc;
    logic          end_char, end_space;

    assign now       = in_data.sample_time_ms[TW-1:0];
    assign in_ready  = cmd_ready;
    assign acc       = in_valid && in_ready;
    assign down_len  = now - down_start_reg;
    assign up_len    = now - up_start_reg;
    assign is_dot    = down_len < TW'(thr_reg);
    assign cnt_inc   = count_reg + 4'd1;
    assign dot3      = 17'(dot_reg) * 17'd3;
    assign dot7      = 18'(dot_reg) * 18'd7;
    assign end_char  = in_data.key_level && prev_reg && (count_reg != 4'd0)
                       && (up_len > TW'(dot3));
    assign end_space = in_data.key_level && prev_reg && (space_reg || end_char)
                       && (up_len > TW'(dot7));

    assign cmd_valid     = acc && (end_char || end_space);
    assign cmd.do_char   = end_char;
    assign cmd.code      = code_reg;
    assign cmd.do_space  = end_space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= 15'd100;
            prev_reg       <= 1'b1;
            down_start_reg <= '0;
            up_start_reg   <= '0;
            dot_reg        <= 15'd100;
            code_reg       <= 8'd1;
            count_reg      <= '0;
            space_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (acc)
            begin
                prev_reg <= in_data.key_level;
                if (in_data.key_level && !prev_reg)
                begin
                    up_start_reg <= now;
                    if (is_dot)
                        dot_reg <= down_len[14:0];
                    if (cnt_inc > 4'(mkd_pkg::MaxElements))
                    begin
                        code_reg  <= 8'd1;
                        count_reg <= '0;
                    end
                    else
                    begin
                        code_reg  <= {code_reg[6:0], !is_dot};
                        count_reg <= cnt_inc;
                    end
                end
                if (!in_data.key_level && prev_reg)
                    down_start_reg <= now;
                if (end_char)
                begin
                    code_reg  <= 8'd1;
                    count_reg <= '0;
                end
                if (end_space)
                    space_reg <= 1'b0;
                else if (end_char)
                    space_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/mkd_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on mkd_pkg.
module mkd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  mkd_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output mkd_pkg::cmd_t rd_data
);

    mkd_pkg::cmd_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== hw/rtl/mkd_back.sv =====
// Back end: table lookup, mode switching, emits character codes one per cycle while out_ready is high.
// Depends on mkd_pkg.
module mkd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mkd_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output mkd_pkg::out_item_t out_data
);

    logic       wabun_reg;
    logic [2:0] idx_reg;
    logic [2:0] len;
    logic [7:0] ch [5];
    logic       nxt_wabun;
    logic [7:0] single;
    logic       pro;
    logic [7:0] pa, pb;
    logic       last, fire;

    always_comb
    begin
        nxt_wabun = wabun_reg;
        pro       = 1'b0;
        pa        = '0;
        pb        = '0;
        single    = mkd_pkg::ChStar;
        if (!wabun_reg)
        begin
            unique case (cmd.code)
                mkd_pkg::CodeAr:   begin pro = 1'b1; pa = 8'd65; pb = 8'd82; end
                mkd_pkg::CodeVa:   begin pro = 1'b1; pa = 8'd86; pb = 8'd65; end
                mkd_pkg::CodeBt:   begin pro = 1'b1; pa = 8'd66; pb = 8'd84; end
                mkd_pkg::CodeToJp: begin nxt_wabun = 1'b1; single = 8'd60; end
                default:           single = mkd_pkg::en_lookup(cmd.code);
            endcase
        end
        else
        begin
            unique case (cmd.code)
                mkd_pkg::CodeToEn:  begin nxt_wabun = 1'b0; single = 8'd62; end
                mkd_pkg::CodeOpen:  begin nxt_wabun = 1'b0; single = 8'd40; end
                mkd_pkg::CodeClose: begin nxt_wabun = 1'b1; single = 8'd41; end
                default:            single = mkd_pkg::jp_lookup(cmd.code);
            endcase
        end
        for (int i = 0; i < 5; i++)
            ch[i] = mkd_pkg::ChSpace;
        if (cmd.do_char)
        begin
            if (pro)
            begin
                ch[0] = mkd_pkg::ChLbr; ch[1] = pa; ch[2] = pb; ch[3] = mkd_pkg::ChRbr;
            end
            else
                ch[0] = single;
        end
        len = 3'(cmd.do_space) + (cmd.do_char ? (pro ? 3'd4 : 3'd1) : 3'd0);
    end

    assign last      = (idx_reg + 3'd1) == len;
    assign out_valid = cmd_valid;
    assign out_data.char_code   = ch[idx_reg];
    assign out_data.last_of_run = last;
    assign fire      = out_valid && out_ready;
    assign cmd_ready = fire && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wabun_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                idx_reg <= '0;
                if (cmd.do_char)
                    wabun_reg <= nxt_wabun;
            end
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

// ===== hw/rtl/mkd_checker.sv =====
// Port-level checker for morse_keying_decoder, bound to the top level.
// Depends on mkd_pkg.
module mkd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input mkd_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request dropped or changed while stalled");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.char_code == mkd_pkg::ChLbr
        |-> !out_data.last_of_run)
        else $error("prosign bracket ended a run");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind morse_keying_decoder mkd_checker u_mkd_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);
